// ----- hw/rtl/iwrm_pkg.sv -----
`default_nettype none

package iwrm_pkg;

  localparam int unsigned RULE_SLOTS = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned WILD_W     = 4;
  localparam int unsigned OCTETS     = 4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_CHECK = 1'b1
  } req_e;

  // One transaction travelling down the cell chain
  typedef struct packed {
    logic              vld;
    req_e              req;
    idx_t              entry_index;
    logic              entry_valid;
    logic              rule_kind;
    logic [ADDR_W-1:0] address;
    logic [WILD_W-1:0] wildcard_mask;
    logic              hit;
    idx_t              hit_index;
  } stage_t;

  // Fixed identity of a cell
  typedef struct packed {
    idx_t id;
    logic writable;
  } slot_t;

endpackage

`default_nettype wire

// ----- hw/rtl/iwrm_if.sv -----
`default_nettype none

interface iwrm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [iwrm_pkg::IDX_W-1:0]  entry_index;
  logic                        entry_valid;
  logic                        rule_kind;
  logic [iwrm_pkg::ADDR_W-1:0] address;
  logic [iwrm_pkg::WILD_W-1:0] wildcard_mask;

  modport source (
    output valid, req_type, entry_index, entry_valid, rule_kind, address, wildcard_mask,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_valid, rule_kind, address, wildcard_mask,
    output ready
  );
endinterface

interface iwrm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       permitted;
  logic [iwrm_pkg::IDX_W-1:0] hit_index;

  modport source (
    output valid, permitted, hit_index,
    input  ready
  );
  modport sink (
    input  valid, permitted, hit_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/iwrm_cell.sv -----
`default_nettype none

module iwrm_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire iwrm_pkg::slot_t  slot_i,
  input  wire iwrm_pkg::stage_t stage_i,
  output iwrm_pkg::stage_t      stage_o
);

  logic                            rule_vld_q;
  logic                            rule_kind_q;
  logic [iwrm_pkg::ADDR_W-1:0]     rule_addr_q;
  logic [iwrm_pkg::WILD_W-1:0]     rule_wild_q;
  logic                            stage_vld_q;
  iwrm_pkg::stage_t                stage_q;
  iwrm_pkg::stage_t                stage_d;
  logic                            wr_sel;
  logic [iwrm_pkg::OCTETS-1:0]     oct_ok;
  logic                            rule_match;

  assign wr_sel = stage_i.vld && (stage_i.req == iwrm_pkg::REQ_WRITE) && slot_i.writable &&
                  (stage_i.entry_index == slot_i.id);

  always_comb begin
    for (int k = 0; k < iwrm_pkg::OCTETS; k++) begin
      oct_ok[k] = rule_wild_q[k] || (rule_addr_q[8*k +: 8] == stage_i.address[8*k +: 8]);
    end
  end

  assign rule_match = rule_vld_q && (rule_kind_q == stage_i.rule_kind) && (&oct_ok);

  always_comb begin
    stage_d = stage_i;
    if (stage_i.vld && (stage_i.req == iwrm_pkg::REQ_CHECK) && !stage_i.hit && rule_match) begin
      stage_d.hit       = 1'b1;
      stage_d.hit_index = slot_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_vld_q  <= 1'b0;
      stage_vld_q <= 1'b0;
    end else if (adv_i) begin
      stage_vld_q <= stage_i.vld;
      if (wr_sel) begin
        rule_vld_q <= stage_i.entry_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
      if (wr_sel) begin
        rule_kind_q <= stage_i.rule_kind;
        rule_addr_q <= stage_i.address;
        rule_wild_q <= stage_i.wildcard_mask;
      end
    end
  end

  always_comb begin
    stage_o     = stage_q;
    stage_o.vld = stage_vld_q;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ipv4_wildcard_rule_match_top.sv -----
// Channel  Dir  Modport  Payload
// in_i     in   sink     req_type, entry_index, entry_valid, rule_kind, address, wildcard_mask
// out_o    out  source   permitted, hit_index (one per check transaction)
//
// One transaction accepted per cycle while no result is held at out_o; a check result passes
// through the first cell, which loads at its accepting edge, then the remaining RULE_SLOTS - 1
// cells and the output register, each of them registered.
// Writes travel the same chain, so every check sees all earlier writes.
// Reset clears every rule valid bit at once; no clearing pass.
// A held result stalls the whole chain and drops in_i.ready.
`default_nettype none

module ipv4_wildcard_rule_match_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  iwrm_in_if.sink     in_i,
  iwrm_out_if.source  out_o
);

  iwrm_pkg::stage_t           chain [iwrm_pkg::RULE_SLOTS+1];
  logic                       adv;
  logic                       out_vld_q;
  logic                       permitted_q;
  iwrm_pkg::idx_t             hit_index_q;
  iwrm_pkg::stage_t           last;

  assign adv = !out_vld_q || out_o.ready;

  always_comb begin
    chain[0].vld           = in_i.valid;
    chain[0].req           = iwrm_pkg::req_e'(in_i.req_type);
    chain[0].entry_index   = in_i.entry_index;
    chain[0].entry_valid   = in_i.entry_valid;
    chain[0].rule_kind     = in_i.rule_kind;
    chain[0].address       = in_i.address;
    chain[0].wildcard_mask = in_i.wildcard_mask;
    chain[0].hit           = 1'b0;
    chain[0].hit_index     = '0;
  end

  for (genvar i = 0; i < iwrm_pkg::RULE_SLOTS; i++) begin : g_cell
    iwrm_pkg::slot_t slot;
    assign slot.id       = iwrm_pkg::idx_t'(i);
    assign slot.writable = (i < (1 << iwrm_pkg::IDX_W));

    iwrm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .slot_i  (slot),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign last = chain[iwrm_pkg::RULE_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= last.vld && (last.req == iwrm_pkg::REQ_CHECK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      permitted_q <= last.hit;
      hit_index_q <= last.hit_index;
    end
  end

  assign in_i.ready      = adv;
  assign out_o.valid     = out_vld_q;
  assign out_o.permitted = permitted_q;
  assign out_o.hit_index = hit_index_q;

endmodule

`default_nettype wire

// ----- hw/rtl/iwrm_checker.sv -----
`default_nettype none

module iwrm_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_i,
  input wire logic                       out_valid_i,
  input wire logic                       out_ready_i,
  input wire logic                       permitted_i,
  input wire logic [iwrm_pkg::IDX_W-1:0] hit_index_i
);

  // a miss always reports slot zero
  a_miss_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !permitted_i |-> hit_index_i == '0)
    else $error("miss with non-zero hit_index");

  // a held result freezes the chain
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result held");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(permitted_i) && $stable(hit_index_i))
    else $error("result changed while stalled");

endmodule

bind ipv4_wildcard_rule_match_top iwrm_checker u_iwrm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .permitted_i (out_o.permitted),
  .hit_index_i (out_o.hit_index)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iwrm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned PAUSE_AT     = 950;
  localparam int unsigned DIR_ROWS     = 25;

  typedef struct packed {
    logic              in_use;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [WILD_W-1:0] wild;
  } acl_rule_t;

  typedef struct packed {
    logic permitted;
    idx_t hit_index;
  } verdict_t;

  typedef struct packed {
    req_e              req;
    idx_t              idx;
    logic              ev;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [WILD_W-1:0] wild;
  } acl_req_t;

  typedef struct packed {
    req_e              req;
    idx_t              idx;
    logic              ev;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [WILD_W-1:0] wild;
    logic              typed;
    logic              permitted;
    idx_t              hit_index;
  } dir_row_t;

  // typed = 1: verdict written in directly; otherwise it comes from the rule lookup
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'h0000_0000, 4'h0, 1'b1, 1'b0, 4'h0},
    '{REQ_CHECK, 4'hf, 1'b1, 1'b1, 32'hffff_ffff, 4'hf, 1'b1, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h0, 1'b1, 1'b0, 32'h0a00_0001, 4'h0, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'h0a00_0001, 4'h0, 1'b1, 1'b1, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b1, 32'h0a00_0001, 4'h0, 1'b1, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'h0a00_0002, 4'h0, 1'b1, 1'b0, 4'h0},
    '{REQ_WRITE, 4'hf, 1'b1, 1'b1, 32'hffff_ffff, 4'hf, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b1, 32'h0000_0000, 4'h0, 1'b1, 1'b1, 4'hf},
    '{REQ_WRITE, 4'h3, 1'b1, 1'b0, 32'hc0a8_0000, 4'h3, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'hc0a8_ffff, 4'h0, 1'b1, 1'b1, 4'h3},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'hc0a9_0000, 4'h0, 1'b1, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h1, 1'b1, 1'b0, 32'h000a_0b0c, 4'h8, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'hff0a_0b0c, 4'h0, 1'b1, 1'b1, 4'h1},
    '{REQ_WRITE, 4'h0, 1'b0, 1'b0, 32'h0a00_0001, 4'h0, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'h0a00_0001, 4'h0, 1'b1, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h2, 1'b1, 1'b0, 32'h0a00_0001, 4'h0, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h7, 1'b1, 1'b0, 32'h0a00_0001, 4'hf, 1'b0, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h5, 1'b1, 1'b1, 32'h1234_5678, 4'hf, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b1, 32'h8765_4321, 4'h0, 1'b0, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h8, 1'b0, 1'b1, 32'hffff_ffff, 4'hf, 1'b0, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h5, 1'b0, 1'b1, 32'h0000_0000, 4'h0, 1'b0, 1'b0, 4'h0},
    '{REQ_WRITE, 4'hf, 1'b0, 1'b1, 32'hffff_ffff, 4'hf, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b1, 32'hffff_ffff, 4'h0, 1'b1, 1'b0, 4'h0},
    '{REQ_WRITE, 4'h4, 1'b1, 1'b0, 32'h0000_0000, 4'h4, 1'b0, 1'b0, 4'h0},
    '{REQ_CHECK, 4'h0, 1'b0, 1'b0, 32'h00ff_0000, 4'h0, 1'b0, 1'b0, 4'h0}
  };

  logic clk_i;
  logic rst_ni;

  iwrm_in_if  in_if ();
  iwrm_out_if out_if ();

  ipv4_wildcard_rule_match_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  acl_rule_t   acl_rules [RULE_SLOTS] = '{default: '0};
  verdict_t    verdict_q [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic verdict_t lookup_acl(logic kind, logic [ADDR_W-1:0] dst);
    verdict_t v;
    bit       agree;
    v = '0;
    // walk downwards so the lowest matching slot wins
    for (int s = RULE_SLOTS - 1; s >= 0; s--) begin
      if (acl_rules[s].in_use && acl_rules[s].kind == kind) begin
        agree = 1'b1;
        for (int o = 0; o < OCTETS; o++) begin
          if (!acl_rules[s].wild[o] && acl_rules[s].addr[8*o +: 8] != dst[8*o +: 8])
            agree = 1'b0;
        end
        if (agree) begin
          v.permitted = 1'b1;
          v.hit_index = IDX_W'(s);
        end
      end
    end
    return v;
  endfunction

  // small address pool so rules overlap and several slots can match
  function automatic logic [ADDR_W-1:0] pick_pool_addr();
    case ($urandom_range(0, 4))
      0:       return {8'd10, 8'd0, 8'd0, 8'($urandom_range(0, 3))};
      1:       return {8'd192, 8'd168, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
      2:       return {8'($urandom_range(0, 1)) * 8'hff, 8'd0, 8'hff, 8'($urandom_range(0, 1))};
      3:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
      default: return {8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                       8'($urandom_range(1, 3)), 8'($urandom_range(1, 3))};
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      quiet_left = $urandom_range(40, 120);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic issue_request(acl_req_t rq, bit typed, verdict_t typed_v);
    in_if.valid         <= 1'b1;
    in_if.req_type      <= rq.req;
    in_if.entry_index   <= rq.idx;
    in_if.entry_valid   <= rq.ev;
    in_if.rule_kind     <= rq.kind;
    in_if.address       <= rq.addr;
    in_if.wildcard_mask <= rq.wild;
    do @(posedge clk_i); while (!in_if.ready);
    if (rq.req == REQ_WRITE) begin
      acl_rules[rq.idx] = '{in_use: rq.ev, kind: rq.kind, addr: rq.addr, wild: rq.wild};
    end else begin
      verdict_q.insert(verdict_q.size(), typed ? typed_v : lookup_acl(rq.kind, rq.addr));
    end
  endtask

  task automatic hold_off(int unsigned n);
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    acl_req_t    rq;
    acl_rule_t   base;
    int unsigned sel;
    int unsigned o;

    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.req_type      <= REQ_WRITE;
    in_if.entry_index   <= '0;
    in_if.entry_valid   <= 1'b0;
    in_if.rule_kind     <= 1'b0;
    in_if.address       <= '0;
    in_if.wildcard_mask <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      rq = '{DIRECTED[i].req, DIRECTED[i].idx, DIRECTED[i].ev, DIRECTED[i].kind,
             DIRECTED[i].addr, DIRECTED[i].wild};
      issue_request(rq, DIRECTED[i].typed, '{DIRECTED[i].permitted, DIRECTED[i].hit_index});
      hold_off(pick_gap());
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      rq.idx  = IDX_W'($urandom);
      rq.ev   = 1'($urandom);
      rq.wild = WILD_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        rq.req  = REQ_WRITE;
        rq.ev   = ($urandom_range(0, 9) != 0);
        rq.kind = 1'($urandom);
        rq.addr = ($urandom_range(0, 9) < 7) ? pick_pool_addr() : ADDR_W'($urandom);
        rq.wild = WILD_W'($urandom) & WILD_W'($urandom);
      end else begin
        rq.req = REQ_CHECK;
        sel    = $urandom_range(0, 99);
        base   = acl_rules[$urandom_range(0, RULE_SLOTS - 1)];
        if (sel < 55) begin
          // aim at a stored rule, scramble its wildcarded octets; sometimes flip the kind or one octet
          rq.kind = ($urandom_range(0, 9) == 0) ? ~base.kind : base.kind;
          rq.addr = base.addr;
          for (int k = 0; k < OCTETS; k++)
            if (base.wild[k]) rq.addr[8*k +: 8] = 8'($urandom);
          if (sel < 12) begin
            o = $urandom_range(0, OCTETS - 1);
            rq.addr[8*o +: 8] = rq.addr[8*o +: 8] ^ 8'($urandom_range(1, 255));
          end
        end else begin
          rq.kind = 1'($urandom);
          rq.addr = (sel < 80) ? pick_pool_addr() : ADDR_W'($urandom);
        end
      end
      issue_request(rq, 1'b0, '0);
      if (n == PAUSE_AT) begin
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (verdict_q.size() != 0);
      end else begin
        hold_off(pick_gap());
      end
    end
    in_if.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (2 * RULE_SLOTS + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned run;
    int unsigned stall;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 70)      run = $urandom_range(1, 8);
      else if (r < 92) run = $urandom_range(9, 40);
      else             run = $urandom_range(100, 300);
      r = $urandom_range(0, 99);
      if (r < 70)      stall = $urandom_range(1, 2);
      else if (r < 95) stall = $urandom_range(3, 8);
      else             stall = $urandom_range(20, 40);
      out_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      out_if.ready <= 1'b0;
      repeat (stall) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected transaction: permitted %0d hit_index %0d",
               out_if.permitted, out_if.hit_index);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.permitted !== want.permitted) begin
          $error("permitted: expected %0d, actual %0d", want.permitted, out_if.permitted);
          error_count++;
        end
        if (out_if.hit_index !== want.hit_index) begin
          $error("hit_index: expected %0d, actual %0d", want.hit_index, out_if.hit_index);
          error_count++;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/iwrm_pkg.sv
hw/rtl/iwrm_if.sv
hw/rtl/iwrm_cell.sv
hw/rtl/ipv4_wildcard_rule_match_top.sv
hw/rtl/iwrm_checker.sv
tb/sv/tb_top.sv
